### hw/rtl/tkukt_pkg.sv
// ----------------------------------------------------------------------------
// tkukt_pkg
// Shared types and constants for the top-k unique key score table.
// ----------------------------------------------------------------------------
package tkukt_pkg;

  localparam int TABLE_DEPTH = 10;
  localparam int KEY_WIDTH   = 32;
  localparam int SCORE_WIDTH = 32;
  localparam int RANK_WIDTH  = 4;
  localparam int IDX_WIDTH   = $clog2(TABLE_DEPTH);

  // command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // result status codes
  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_IMPROVED = 3'd1;
  localparam logic [2:0] STAT_IGNORED  = 3'd2;
  localparam logic [2:0] STAT_DROPPED  = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;

  typedef struct packed {
    logic                          command;
    logic [KEY_WIDTH-1:0]          player_key;
    logic signed [SCORE_WIDTH-1:0] score;
    logic [RANK_WIDTH-1:0]         rank_query;
  } in_req_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic [RANK_WIDTH-1:0]         rank;
    logic                          entry_valid;
    logic [KEY_WIDTH-1:0]          entry_key;
    logic signed [SCORE_WIDTH-1:0] entry_score;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REMOVE,
    ST_SEARCH,
    ST_INSERT,
    ST_READ,
    ST_DONE
  } tkukt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic match;
    logic remove;
    logic search;
    logic insert;
    logic read;
    logic load_out;
  } tkukt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found;
    logic better;
  } tkukt_stat_t;

endpackage

### hw/rtl/tkukt_ctrl.sv
// ----------------------------------------------------------------------------
// tkukt_ctrl
// Sequencer for the score table: steps each request through match, remove,
// search and insert (or read), and owns both handshakes.
// ----------------------------------------------------------------------------
module tkukt_ctrl
  import tkukt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_command,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output tkukt_cmd_t  cmd,
  input  tkukt_stat_t stat
);

  tkukt_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = (in_command == CMD_READ) ? ST_READ : ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_REMOVE;
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = (stat.found && !stat.better) ? ST_DONE : ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  // a result only appears after the finishing step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside of the finishing step");

  // an accepted request always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_MATCH || state_r == ST_READ))
    else $error("accepted request did not start");

endmodule

### hw/rtl/tkukt_dp.sv
// ----------------------------------------------------------------------------
// tkukt_dp
// Datapath of the score table: slot registers, key match, removal shift,
// insert position search, insertion shift, read mux and output register.
// ----------------------------------------------------------------------------
module tkukt_dp
  import tkukt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_req_t     in_req,
  input  tkukt_cmd_t  cmd,
  output tkukt_stat_t stat,
  output out_rsp_t    out_rsp
);

  in_req_t                       req_r;
  logic signed [SCORE_WIDTH-1:0] slot_score_r [TABLE_DEPTH];
  logic signed [SCORE_WIDTH-1:0] slot_score_nxt [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]          slot_key_r [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]          slot_key_nxt [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        slot_valid_r, slot_valid_nxt;

  logic                 found_r, better_r, fit_r;
  logic [IDX_WIDTH-1:0] idx_r, pos_r;
  out_rsp_t             res_r, res_nxt;
  out_rsp_t             out_rsp_r;

  logic                   match_found;
  logic [IDX_WIDTH-1:0]   match_idx;
  logic                   match_better;
  logic [TABLE_DEPTH-1:0] lower;
  logic [IDX_WIDTH-1:0]   lower_idx;
  logic                   rd_in_range;
  logic [IDX_WIDTH-1:0]   rd_idx;

  // key match: keys are unique, lowest slot wins anyway
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
      if (slot_valid_r[j] && slot_key_r[j] == req_r.player_key) begin
        match_found = 1'b1;
        match_idx   = IDX_WIDTH'(j);
      end
    end
  end

  assign match_better = req_r.score > slot_score_r[match_idx];

  // first slot that is empty or strictly lower
  always_comb begin
    lower_idx = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      lower[j] = !slot_valid_r[j] || (req_r.score > slot_score_r[j]);
    end
    for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
      if (lower[j]) lower_idx = IDX_WIDTH'(j);
    end
  end

  assign rd_in_range = int'(req_r.rank_query) < TABLE_DEPTH;
  assign rd_idx      = rd_in_range ? req_r.rank_query[IDX_WIDTH-1:0] : '0;

  always_comb begin
    slot_score_nxt = slot_score_r;
    slot_key_nxt   = slot_key_r;
    slot_valid_nxt = slot_valid_r;
    res_nxt        = res_r;

    if (cmd.remove && found_r) begin
      if (better_r) begin
        // close up below the old entry, empty the last slot
        for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
          if (j >= int'(idx_r)) begin
            slot_score_nxt[j] = slot_score_r[j+1];
            slot_key_nxt[j]   = slot_key_r[j+1];
            slot_valid_nxt[j] = slot_valid_r[j+1];
          end
        end
        slot_score_nxt[TABLE_DEPTH-1] = '0;
        slot_valid_nxt[TABLE_DEPTH-1] = 1'b0;
      end else begin
        res_nxt        = '0;
        res_nxt.status = STAT_IGNORED;
        res_nxt.rank   = RANK_WIDTH'(TABLE_DEPTH);
      end
    end

    if (cmd.insert) begin
      res_nxt = '0;
      if (fit_r) begin
        for (int j = 1; j < TABLE_DEPTH; j++) begin
          if (j > int'(pos_r)) begin
            slot_score_nxt[j] = slot_score_r[j-1];
            slot_key_nxt[j]   = slot_key_r[j-1];
            slot_valid_nxt[j] = slot_valid_r[j-1];
          end
        end
        slot_score_nxt[pos_r] = req_r.score;
        slot_key_nxt[pos_r]   = req_r.player_key;
        slot_valid_nxt[pos_r] = 1'b1;
        res_nxt.status        = (found_r && better_r) ? STAT_IMPROVED : STAT_INSERTED;
        res_nxt.rank          = RANK_WIDTH'(pos_r);
      end else begin
        res_nxt.status = STAT_DROPPED;
        res_nxt.rank   = RANK_WIDTH'(TABLE_DEPTH);
      end
    end

    if (cmd.read) begin
      res_nxt        = '0;
      res_nxt.status = STAT_READ;
      res_nxt.rank   = RANK_WIDTH'(TABLE_DEPTH);
      if (rd_in_range && slot_valid_r[rd_idx]) begin
        res_nxt.entry_valid = 1'b1;
        res_nxt.entry_key   = slot_key_r[rd_idx];
        res_nxt.entry_score = slot_score_r[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      for (int j = 0; j < TABLE_DEPTH; j++) slot_score_r[j] <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      slot_score_r <= slot_score_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_key_r <= slot_key_nxt;
    res_r      <= res_nxt;
    if (cmd.load_req) req_r <= in_req;
    if (cmd.match) begin
      found_r  <= match_found;
      better_r <= match_better;
      idx_r    <= match_idx;
    end
    if (cmd.search) begin
      fit_r <= |lower;
      pos_r <= lower_idx;
    end
    if (cmd.load_out) out_rsp_r <= res_r;
  end

  assign stat.found  = found_r;
  assign stat.better = better_r;
  assign out_rsp     = out_rsp_r;

  logic [TABLE_DEPTH-1:0] valid_inc;
  assign valid_inc = slot_valid_r + TABLE_DEPTH'(1);

  // occupied slots always form a prefix of the table
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_valid_r & valid_inc) == '0)
    else $error("occupied slots are not contiguous");

  // an insert that fits leaves its slot occupied
  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && fit_r) |=> slot_valid_r[$past(pos_r)])
    else $error("inserted slot is empty");

endmodule

### hw/rtl/top_k_unique_key_table.sv
// ----------------------------------------------------------------------------
// top_k_unique_key_table
// Descending top-k score table with at most one entry per player key.
// ----------------------------------------------------------------------------
// One request is worked at a time by a small sequencer over a register-based
// table of TABLE_DEPTH slots. An offer walks accept, key match, old-entry
// removal, insert position search, insertion and result load; an offer that
// does not beat its own stored score skips the search and insertion, and a
// read walks accept, read and result load, each step one sequencer state.
// in_stall is low only while the sequencer is idle; the result sits in an
// output register, so the block stays idle and ready for the next request
// while a finished result waits behind out_stall, and only stalls in its last
// step if the previous result has still not been taken. Read of a rank at or
// beyond TABLE_DEPTH returns an empty entry. Reset empties the table.
// ----------------------------------------------------------------------------
module top_k_unique_key_table
  import tkukt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // request channel
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  // result channel
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  tkukt_cmd_t  cmd;
  tkukt_stat_t stat;

  // sequencer and handshakes
  tkukt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_req.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // slot table, compare and shift logic, output register
  tkukt_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_rsp (out_rsp)
  );

endmodule
